/* sv/length_checksum_frame_receiver_macros.svh */
// Assertion macros for the frame receiver.
// Needs nothing else; included by the top level only.
`ifndef LENGTH_CHECKSUM_FRAME_RECEIVER_MACROS_SVH
`define LENGTH_CHECKSUM_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define LCFR_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lcfr: check failed");

// Next-cycle implication, disabled during reset.
`define LCFR_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> cons) \
      else $error("lcfr: check failed");

`endif

/* sv/lcfr_pkg.sv */
// Shared types and constants for the frame receiver.
// No dependencies.
`default_nettype none

package lcfr_pkg;

   localparam int MAX_FRAME = 64;
   localparam int CNT_W     = $clog2(MAX_FRAME + 1);
   localparam int IDX_W     = $clog2(MAX_FRAME);
   localparam int BYTE_W    = 8;
   localparam int TOTAL_W   = 9;
   localparam int ADDR_W    = 2;

   // position of the length byte, and bytes in a frame besides the payload
   localparam logic [CNT_W-1:0]   LEN_POS        = CNT_W'(4);
   localparam logic [TOTAL_W-1:0] FRAME_OVERHEAD = TOTAL_W'(7);

   localparam logic [ADDR_W-1:0] REG_HEADER  = 2'd0;
   localparam logic [ADDR_W-1:0] REG_TAIL    = 2'd1;
   localparam logic [ADDR_W-1:0] REG_MAX_LEN = 2'd2;

   typedef enum logic [1:0] {
      ST_RECV,
      ST_FETCH,
      ST_SHOW
   } lcfr_state_type;

   typedef struct packed {
      logic accept;   // input byte transfer this cycle
      logic fetch;    // load output register from the frame buffer
      logic advance;  // step to the next buffered byte
   } lcfr_cmd_type;

   typedef struct packed {
      logic frame_ok; // accepted byte completes a good frame
      logic out_last; // output register holds the final byte
   } lcfr_status_type;

endpackage

`default_nettype wire

/* sv/lcfr_datapath.sv */
// Datapath: byte counter, running sum, frame buffer and output register.
// Depends on lcfr_pkg.
`default_nettype none

module lcfr_datapath (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire lcfr_pkg::lcfr_cmd_type        cmd,
   output lcfr_pkg::lcfr_status_type          status,
   input  wire logic [lcfr_pkg::BYTE_W-1:0]   rx_byte,
   input  wire logic [lcfr_pkg::BYTE_W-1:0]   header_code,
   input  wire logic [lcfr_pkg::BYTE_W-1:0]   tail_code,
   input  wire logic [lcfr_pkg::CNT_W-1:0]    max_frame_len,
   output logic      [lcfr_pkg::BYTE_W-1:0]   frame_byte,
   output logic      [lcfr_pkg::IDX_W-1:0]    byte_index,
   output logic                               last_byte
);
   import lcfr_pkg::*;

   logic [CNT_W-1:0]   count_ff, count_in, count_inc, limit;
   logic [TOTAL_W-1:0] total_ff, total_in, total_new;
   logic [BYTE_W-1:0]  sum_ff, sum_in;
   logic [BYTE_W-1:0]  prev_ff, prev_in;
   logic [IDX_W-1:0]   rd_idx_ff, end_ff;
   logic [BYTE_W-1:0]  out_byte_ff;
   logic [IDX_W-1:0]   out_idx_ff;
   logic               out_last_ff;
   logic               wr_en, done, frame_ok;
   logic [BYTE_W-1:0]  frame_mem [MAX_FRAME];

   assign limit = (max_frame_len == '0 || max_frame_len > CNT_W'(MAX_FRAME))
                  ? CNT_W'(MAX_FRAME) : max_frame_len;
   assign count_inc = count_ff + CNT_W'(1);
   assign total_new = (count_ff == LEN_POS)
                      ? {{(TOTAL_W-BYTE_W){1'b0}}, rx_byte} + FRAME_OVERHEAD
                      : total_ff;

   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      sum_in   = sum_ff;
      prev_in  = prev_ff;
      wr_en    = 1'b0;
      done     = 1'b0;
      frame_ok = 1'b0;
      if (cmd.accept) begin
         if (count_ff == '0) begin
            if (rx_byte == header_code) begin
               wr_en    = 1'b1;
               prev_in  = rx_byte;
               sum_in   = rx_byte;
               count_in = CNT_W'(1);
               if (CNT_W'(1) >= limit) begin
                  count_in = '0;
                  sum_in   = '0;
               end
            end
         end else begin
            wr_en    = 1'b1;
            prev_in  = rx_byte;
            sum_in   = sum_ff + rx_byte;
            total_in = total_new;
            count_in = count_inc;
            done     = (total_new != '0) &&
                       ({{(TOTAL_W-CNT_W){1'b0}}, count_inc} == total_new);
            // tail sits in the byte before the checksum
            frame_ok = done && (prev_ff == tail_code) && (sum_ff == rx_byte);
            if (done || count_inc >= limit) begin
               count_in = '0;
               total_in = '0;
               sum_in   = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         total_ff  <= '0;
         sum_ff    <= '0;
         rd_idx_ff <= '0;
      end else begin
         count_ff <= count_in;
         total_ff <= total_in;
         sum_ff   <= sum_in;
         if (frame_ok) begin
            rd_idx_ff <= '0;
         end else if (cmd.advance) begin
            rd_idx_ff <= rd_idx_ff + IDX_W'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      if (frame_ok) begin
         end_ff <= count_ff[IDX_W-1:0];
      end
      if (cmd.fetch) begin
         out_idx_ff  <= rd_idx_ff;
         out_last_ff <= (rd_idx_ff == end_ff);
      end
   end

   // frame buffer: one write port, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         frame_mem[count_ff[IDX_W-1:0]] <= rx_byte;
      end
      if (cmd.fetch) begin
         out_byte_ff <= frame_mem[rd_idx_ff];
      end
   end

   assign status.frame_ok = frame_ok;
   assign status.out_last = out_last_ff;
   assign frame_byte      = out_byte_ff;
   assign byte_index      = out_idx_ff;
   assign last_byte       = out_last_ff;

endmodule

`default_nettype wire

/* sv/lcfr_ctrl.sv */
// Controller: receive / fetch / show sequencing and stream handshakes.
// Depends on lcfr_pkg.
`default_nettype none

module lcfr_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       in_valid,
   output logic                            in_ready,
   output logic                            out_valid,
   input  wire logic                       out_ready,
   input  wire lcfr_pkg::lcfr_status_type  status,
   output lcfr_pkg::lcfr_cmd_type          cmd
);
   import lcfr_pkg::*;

   lcfr_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RECV;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      in_ready  = 1'b0;
      out_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         ST_RECV: begin
            in_ready   = 1'b1;
            cmd.accept = in_valid;
            if (in_valid && status.frame_ok) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_SHOW;
         end
         ST_SHOW: begin
            out_valid = 1'b1;
            if (out_ready) begin
               if (status.out_last) begin
                  state_in = ST_RECV;
               end else begin
                  cmd.advance = 1'b1;
                  state_in    = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_RECV;
         end
      endcase
   end

endmodule

`default_nettype wire

/* sv/length_checksum_frame_receiver.sv */
// Frame receiver top: config registers, controller and datapath.
// A good frame starts out after its last byte: the controller passes through fetch (buffer read) into show.
// Throughput: one input byte a cycle while receiving; a good frame is then sent out with a buffer
// read plus an output transfer per byte, input stalled meanwhile.
// Reset (synchronous, high): counters cleared, header 0, tail 0, max length 64.
// Depends on lcfr_pkg and length_checksum_frame_receiver_macros.svh.
`default_nettype none

module length_checksum_frame_receiver (
   input  wire logic                         clock,
   input  wire logic                         reset,
   // input stream
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   input  wire logic [7:0]                   req_tdata,   // [7:0] rx_byte
   // result stream
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   output logic      [15:0]                  rsp_tdata,   // [7:0] frame_byte, [13:8] byte_index
   output logic                              rsp_tlast,   // last_byte
   // configuration writes
   input  wire logic                         csr_we,
   input  wire logic [lcfr_pkg::ADDR_W-1:0]  csr_addr,
   input  wire logic [7:0]                   csr_wdata
);
   import lcfr_pkg::*;

   logic [BYTE_W-1:0] header_ff, tail_ff;
   logic [CNT_W-1:0]  max_len_ff;
   lcfr_cmd_type      cmd;
   lcfr_status_type   status;
   logic [BYTE_W-1:0] frame_byte;
   logic [IDX_W-1:0]  byte_index;
   logic              last_byte;

   // config registers; writes to unused indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         header_ff  <= '0;
         tail_ff    <= '0;
         max_len_ff <= CNT_W'(MAX_FRAME);
      end else if (csr_we) begin
         unique case (csr_addr)
            REG_HEADER:  header_ff  <= csr_wdata;
            REG_TAIL:    tail_ff    <= csr_wdata;
            REG_MAX_LEN: max_len_ff <= csr_wdata[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   lcfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .status    (status),
      .cmd       (cmd)
   );

   lcfr_datapath u_datapath (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .rx_byte       (req_tdata),
      .header_code   (header_ff),
      .tail_code     (tail_ff),
      .max_frame_len (max_len_ff),
      .frame_byte    (frame_byte),
      .byte_index    (byte_index),
      .last_byte     (last_byte)
   );

   assign rsp_tdata = {2'b00, byte_index, frame_byte};
   assign rsp_tlast = last_byte;

   // ---- checks ----
   `include "length_checksum_frame_receiver_macros.svh"

   // no byte taken while a frame is being sent out
   `LCFR_ASSERT_IMP(a_no_rx_during_tx, clock, reset, rsp_tvalid, !req_tready)
   // a non-final output transfer is followed by the next byte after a buffer fetch
   `LCFR_ASSERT_NXT(a_tx_continues, clock, reset,
                    rsp_tvalid && rsp_tready && !rsp_tlast, ##1 rsp_tvalid)
   // and its index is one higher
   `LCFR_ASSERT_NXT(a_tx_index_step, clock, reset,
                    rsp_tvalid && rsp_tready && !rsp_tlast,
                    ##1 (byte_index == $past(byte_index, 2) + IDX_W'(1)))
   // a frame starts at index zero
   `LCFR_ASSERT_IMP(a_tx_first_index, clock, reset,
                    $rose(rsp_tvalid) && $past(req_tready, 2), byte_index == '0)

endmodule

`default_nettype wire
